@@ sv/bqeq_pkg.sv @@
// shared types and constants for the biquad cascade equalizer
package bqeq_pkg;

    localparam int HIST_W     = 32;
    localparam int COEF_W     = 32;
    localparam int MASK_W     = 10;
    localparam int CH_W       = 3;
    localparam int BAND_W     = 4;
    localparam int CIDX_W     = 3;
    localparam int STEP_W     = 3;
    localparam int NUM_COEFFS = 5;

    localparam logic [MASK_W-1:0] MASK_RESET = 10'h3FF;

    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    typedef struct packed {
        logic clear;
        logic mul_en;
        logic acc_en;
        logic negate;
    } t_mac_ctrl;

endpackage

@@ sv/bqeq_ram.sv @@
// generic simple dual-port ram with registered read
module bqeq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/bqeq_mac.sv @@
// shared multiplier, accumulator and round/saturate for one biquad band
module bqeq_mac #(
    parameter int COEFF_FRAC_BITS = 28
) (
    input  logic                                    i_clk,
    input  bqeq_pkg::t_mac_ctrl                     i_ctrl,
    input  logic signed [bqeq_pkg::COEF_W-1:0]      i_coef,
    input  logic signed [bqeq_pkg::HIST_W-1:0]      i_operand,
    output logic signed [bqeq_pkg::HIST_W-1:0]      o_y,
    output logic                                    o_clip
);
    import bqeq_pkg::*;

    localparam int ACC_W  = COEF_W + HIST_W + 3;
    localparam int PROD_W = COEF_W + HIST_W;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (COEFF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] YMAX = ACC_W'({1'b0, {(HIST_W-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] YMIN = ~YMAX;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_neg;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  w_prod_ext;
    logic signed [ACC_W-1:0]  w_round;

    assign w_prod_ext = ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= i_coef * i_operand;
            r_neg  <= i_ctrl.negate;
        end
        if (i_ctrl.clear) begin
            r_acc <= '0;
        end else if (i_ctrl.acc_en) begin
            if (r_neg) begin
                r_acc <= r_acc - w_prod_ext;
            end else begin
                r_acc <= r_acc + w_prod_ext;
            end
        end
    end

    always_comb begin
        w_round = (r_acc + HALF) >>> COEFF_FRAC_BITS;
        o_clip  = 1'b0;
        if (w_round > YMAX) begin
            o_y    = YMAX[HIST_W-1:0];
            o_clip = 1'b1;
        end else if (w_round < YMIN) begin
            o_y    = YMIN[HIST_W-1:0];
            o_clip = 1'b1;
        end else begin
            o_y = w_round[HIST_W-1:0];
        end
    end

endmodule

@@ sv/biquad_cascade_equalizer_core.sv @@
// biquad cascade equalizer top level: sequencer, coefficient and history rams
// a sample passes through the bands in turn on the shared multiplier; a bypassed band is skipped
// (an active band reads its coefficients and history, multiplies, accumulates and writes history back)
// a coefficient write needs no sequencing, an out-of-range channel skips the bands; one item at a time
// a finished result waits in an output register; after reset a clearing pass
// loads the rams, config always taken
module biquad_cascade_equalizer_core #(
    parameter int NUM_BANDS       = 10,
    parameter int NUM_CHANNELS    = 8,
    parameter int SAMPLE_BITS     = 24,
    parameter int COEFF_FRAC_BITS = 28
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_opcode,
    input  logic [bqeq_pkg::CH_W-1:0]              i_channel,
    input  logic signed [SAMPLE_BITS-1:0]          i_sample,
    input  logic [bqeq_pkg::BAND_W-1:0]            i_band,
    input  logic [bqeq_pkg::CIDX_W-1:0]            i_coeff_index,
    input  logic signed [bqeq_pkg::COEF_W-1:0]     i_coeff_value,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [bqeq_pkg::CH_W-1:0]              o_out_channel,
    output logic signed [SAMPLE_BITS-1:0]          o_out_sample,
    output logic                                   o_saturated,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [bqeq_pkg::MASK_W-1:0]            i_cfg_data
);
    import bqeq_pkg::*;

    localparam int HDEPTH  = NUM_CHANNELS * NUM_BANDS;
    localparam int CDEPTH  = NUM_BANDS * NUM_COEFFS;
    localparam int HA_W    = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
    localparam int CA_W    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam int CLR_LEN = (HDEPTH > CDEPTH) ? HDEPTH : CDEPTH;
    localparam int CLR_W   = $clog2(CLR_LEN + 1);
    localparam int HWORD_W = 4 * HIST_W;
    localparam int MEXT_W  = 2 ** BAND_W;

    localparam logic [STEP_W-1:0] STEP_LAST_MUL = 3'd5;
    localparam logic [STEP_W-1:0] STEP_LAST_ACC = 3'd6;
    localparam logic [STEP_W-1:0] STEP_WB       = 3'd7;

    localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) <<< COEFF_FRAC_BITS;
    localparam logic signed [HIST_W-1:0] SMAX = HIST_W'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    localparam logic signed [HIST_W-1:0] SMIN = ~SMAX;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    t_state                    r_state;
    logic [CLR_W-1:0]          r_clr;
    logic [2:0]                r_clr_k;
    logic [MASK_W-1:0]         r_bypass;
    logic [CH_W-1:0]           r_ch;
    logic signed [HIST_W-1:0]  r_x;
    logic                      r_clip;
    logic [BAND_W-1:0]         r_band;
    logic [STEP_W-1:0]         r_step;
    logic                      r_out_valid;
    logic [CH_W-1:0]           r_out_channel;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic                      r_out_sat;

    logic                      w_in_xfer;
    logic                      w_out_xfer;
    logic                      w_item_ok;
    logic [MEXT_W-1:0]         w_mask_ext;
    logic                      w_bypass;
    logic                      w_last_band;
    logic                      c_we;
    logic [CA_W-1:0]           c_waddr;
    logic [COEF_W-1:0]         c_wdata;
    logic                      c_re;
    logic [CA_W-1:0]           c_raddr;
    logic [COEF_W-1:0]         c_rdata;
    logic                      h_we;
    logic [HA_W-1:0]           h_waddr;
    logic [HWORD_W-1:0]        h_wdata;
    logic                      h_re;
    logic [HA_W-1:0]           h_addr;
    logic [HWORD_W-1:0]        h_rdata;
    t_mac_ctrl                 w_mac;
    logic signed [HIST_W-1:0]  w_operand;
    logic signed [HIST_W-1:0]  w_y;
    logic                      w_yclip;
    logic signed [HIST_W-1:0]  w_fin;
    logic                      w_fin_clip;

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_out_channel = r_out_channel;
    assign o_out_sample  = r_out_sample;
    assign o_saturated   = r_out_sat;

    assign w_in_xfer   = i_in_valid && (r_state == S_IDLE);
    assign w_out_xfer  = r_out_valid && !i_out_stall;
    assign w_item_ok   = (int'(i_band) < NUM_BANDS) && (int'(i_coeff_index) < NUM_COEFFS);
    assign w_mask_ext  = MEXT_W'(r_bypass);
    assign w_bypass    = w_mask_ext[r_band];
    assign w_last_band = (r_band == BAND_W'(NUM_BANDS - 1));
    assign h_addr      = HA_W'(int'(r_ch) * NUM_BANDS + int'(r_band));

    always_comb begin
        w_fin_clip = 1'b0;
        if (r_x > SMAX) begin
            w_fin      = SMAX;
            w_fin_clip = 1'b1;
        end else if (r_x < SMIN) begin
            w_fin      = SMIN;
            w_fin_clip = 1'b1;
        end else begin
            w_fin = r_x;
        end
    end

    always_comb begin
        unique case (r_step)
            3'd2:    w_operand = h_rdata[HIST_W-1:0];
            3'd3:    w_operand = h_rdata[2*HIST_W-1:HIST_W];
            3'd4:    w_operand = h_rdata[3*HIST_W-1:2*HIST_W];
            3'd5:    w_operand = h_rdata[4*HIST_W-1:3*HIST_W];
            default: w_operand = r_x;
        endcase
    end

    always_comb begin
        w_mac   = '0;
        c_re    = 1'b0;
        h_re    = 1'b0;
        c_raddr = CA_W'(int'(r_band) * NUM_COEFFS + int'(r_step));

        if (r_state == S_CLEAR) begin
            c_we    = (r_clr < CLR_W'(CDEPTH));
            c_waddr = r_clr[CA_W-1:0];
            c_wdata = (r_clr_k == 3'd0) ? COEF_ONE : '0;
            h_we    = (r_clr < CLR_W'(HDEPTH));
            h_waddr = r_clr[HA_W-1:0];
            h_wdata = '0;
        end else begin
            c_we    = w_in_xfer && (i_opcode == OP_WRITE) && w_item_ok;
            c_waddr = CA_W'(int'(i_band) * NUM_COEFFS + int'(i_coeff_index));
            c_wdata = i_coeff_value;
            h_we    = (r_state == S_RUN) && (r_step == STEP_WB);
            h_waddr = h_addr;
            h_wdata = {h_rdata[3*HIST_W-1:2*HIST_W], w_y,
                       h_rdata[HIST_W-1:0], r_x};
        end

        if (r_state == S_RUN) begin
            if (r_step == 3'd0) begin
                c_re = !w_bypass;
                h_re = !w_bypass;
            end else if (r_step <= STEP_LAST_MUL) begin
                w_mac.mul_en = 1'b1;
                w_mac.negate = (r_step >= 3'd4);
                w_mac.clear  = (r_step == 3'd1);
                w_mac.acc_en = (r_step >= 3'd2);
                c_re         = (r_step < STEP_LAST_MUL);
            end else if (r_step == STEP_LAST_ACC) begin
                w_mac.acc_en = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_clr_k     <= '0;
            r_bypass    <= MASK_RESET;
            r_out_valid <= 1'b0;
            r_band      <= '0;
            r_step      <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_bypass <= i_cfg_data;
            end
            if (w_out_xfer && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr   <= r_clr + 1'b1;
                    r_clr_k <= (r_clr_k == 3'(NUM_COEFFS - 1)) ? 3'd0 : r_clr_k + 3'd1;
                    if (r_clr == CLR_W'(CLR_LEN - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_in_xfer && (i_opcode == OP_FILTER)) begin
                        r_ch   <= i_channel;
                        r_x    <= HIST_W'(i_sample);
                        r_clip <= 1'b0;
                        r_band <= '0;
                        r_step <= '0;
                        if (int'(i_channel) < NUM_CHANNELS) begin
                            r_state <= S_RUN;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_RUN: begin
                    if (r_step == 3'd0) begin
                        if (w_bypass) begin
                            if (w_last_band) begin
                                r_state <= S_DONE;
                            end else begin
                                r_band <= r_band + 1'b1;
                            end
                        end else begin
                            r_step <= 3'd1;
                        end
                    end else if (r_step == STEP_WB) begin
                        r_x    <= w_y;
                        r_clip <= r_clip | w_yclip;
                        r_step <= '0;
                        if (w_last_band) begin
                            r_state <= S_DONE;
                        end else begin
                            r_band <= r_band + 1'b1;
                        end
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || w_out_xfer) begin
                        r_out_valid   <= 1'b1;
                        r_out_channel <= r_ch;
                        r_out_sample  <= w_fin[SAMPLE_BITS-1:0];
                        r_out_sat     <= r_clip | w_fin_clip;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    bqeq_ram #(
        .WIDTH (COEF_W),
        .DEPTH (CDEPTH)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_re    (c_re),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    bqeq_ram #(
        .WIDTH (HWORD_W),
        .DEPTH (HDEPTH)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_re    (h_re),
        .i_raddr (h_addr),
        .o_rdata (h_rdata)
    );

    bqeq_mac #(
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_mac (
        .i_clk     (i_clk),
        .i_ctrl    (w_mac),
        .i_coef    (c_rdata),
        .i_operand (w_operand),
        .o_y       (w_y),
        .o_clip    (w_yclip)
    );

endmodule
